FILE: design/sclt_pkg.sv
// Package for the sorted code lookup table.
// Holds field widths, command and status codes, and the result struct.
// No dependencies.
`default_nettype none

package sclt_pkg;

    localparam int CODE_W = 16;
    localparam int CHAR_W = 8;
    localparam int ENTRY_W = CODE_W + CHAR_W;
    localparam int TABLE_DEPTH_DEF = 256;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic              status;
        logic              caps;
        logic [CHAR_W-1:0] ch;
    } res_t;

endpackage

`default_nettype wire

FILE: design/sclt_mem.sv
// Table storage for the sorted code lookup table: one write port, one read port.
// Read data is registered. Depends on nothing.
`default_nettype none

module sclt_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 24
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/sclt_ctrl.sv
// Sequencer for the sorted code lookup table: sorted insert and binary search.
// The code comparisons work on one table read per step. Uses sclt_pkg and sclt_mem.
`default_nettype none

module sclt_ctrl
    import sclt_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              cmd,
    input  wire logic [CODE_W-1:0] key_code,
    input  wire logic [CHAR_W-1:0] char_in,
    input  wire logic              caps,
    output logic                   busy,
    output res_t                   res
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_INS_RD  = 3'd1;
    localparam logic [2:0] ST_INS_CMP = 3'd2;
    localparam logic [2:0] ST_INS_WR  = 3'd3;
    localparam logic [2:0] ST_LK_CHK  = 3'd4;
    localparam logic [2:0] ST_LK_CMP  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    res_t              res_reg, res_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic              caps_reg, caps_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  mid_reg, mid_next;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;
    logic [CODE_W-1:0]  rd_code;
    logic [CNT_W:0]     mid_sum;

    sclt_mem #(
        .DEPTH(DEPTH),
        .WIDTH(ENTRY_W)
    ) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign rd_code = mem_rdata[ENTRY_W-1:CHAR_W];
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (CNT_W + 1)'(1);
    assign busy = (state_reg != ST_IDLE);
    assign res = res_reg;

    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        code_next  = code_reg;
        ch_next    = ch_reg;
        caps_next  = caps_reg;
        pos_next   = pos_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        res_next   = '0;
        mem_we     = 1'b0;
        mem_waddr  = pos_reg;
        mem_wdata  = {code_reg, ch_reg};
        mem_re     = 1'b0;
        mem_raddr  = pos_reg - IDX_W'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    code_next = key_code;
                    ch_next   = char_in;
                    caps_next = caps;
                    if (cmd == CMD_INSERT)
                    begin
                        if (used_reg == FULL_CNT)
                        begin
                            res_next.valid  = 1'b1;
                            res_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            pos_next = used_reg[IDX_W-1:0];
                            state_next = (used_reg == '0) ? ST_INS_WR : ST_INS_RD;
                        end
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = used_reg;
                        state_next = ST_LK_CHK;
                    end
                end
            end
            ST_INS_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                if (rd_code > code_reg)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = mem_rdata;
                    pos_next   = pos_reg - IDX_W'(1);
                    state_next = (pos_reg == IDX_W'(1)) ? ST_INS_WR : ST_INS_RD;
                end
                else
                begin
                    state_next = ST_INS_WR;
                end
            end
            ST_INS_WR:
            begin
                mem_we          = 1'b1;
                used_next       = used_reg + CNT_W'(1);
                res_next.valid  = 1'b1;
                res_next.status = STATUS_OK;
                state_next      = ST_IDLE;
            end
            ST_LK_CHK:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_sum[CNT_W:1];
                    mem_re     = 1'b1;
                    mem_raddr  = mid_sum[IDX_W:1];
                    state_next = ST_LK_CMP;
                end
                else
                begin
                    res_next.valid = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_LK_CMP:
            begin
                if (rd_code == code_reg)
                begin
                    res_next.valid = 1'b1;
                    res_next.hit   = 1'b1;
                    res_next.caps  = caps_reg;
                    res_next.ch    = mem_rdata[CHAR_W-1:0];
                    state_next     = ST_IDLE;
                end
                else if (rd_code < code_reg)
                begin
                    lo_next    = mid_reg + CNT_W'(1);
                    state_next = ST_LK_CHK;
                end
                else
                begin
                    hi_next    = mid_reg;
                    state_next = ST_LK_CHK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        ch_reg   <= ch_next;
        caps_reg <= caps_next;
        pos_reg  <= pos_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
    end

endmodule

`default_nettype wire

FILE: design/sorted_code_lookup_table.sv
// Top level of the sorted code lookup table: sequencer plus result register with case folding.
// Uses sclt_pkg and sclt_ctrl.
//
//   Channel   Handshake          Ports
//   command   start, busy        cmd, key_code, char_in, caps
//   result    done (strobe)      hit, char_out, status
//
// A lookup runs a check and a compare state per probe, at most floor(log2(entries)) + 1 probes,
// plus a final check on a miss. An insert runs a read and a compare state per entry moved up,
// then read, compare and write, or only the write at the front or in an empty table; a refused
// insert never raises busy. done rises in the cycle after busy falls; a refused insert's result
// passes through the result and done registers. The single registered read port sets this pace.
// Reset empties the table at once; no clearing pass is needed.
// Results cannot be stalled: done is high for one cycle per transaction.
`default_nettype none

module sorted_code_lookup_table
    import sclt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              cmd,
    input  wire logic [CODE_W-1:0] key_code,
    input  wire logic [CHAR_W-1:0] char_in,
    input  wire logic              caps,
    output logic                   done,
    output logic                   hit,
    output logic      [CHAR_W-1:0] char_out,
    output logic                   status
);

    localparam logic [CHAR_W-1:0] UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

    res_t              res;
    logic              ctrl_busy;
    logic [CHAR_W-1:0] char_fold;
    logic              done_reg;
    logic              hit_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              status_reg;

    sclt_ctrl #(
        .DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .key_code(key_code),
        .char_in (char_in),
        .caps    (caps),
        .busy    (ctrl_busy),
        .res     (res)
    );

    always_comb
    begin
        char_fold = res.ch;
        if (!res.hit)
        begin
            char_fold = '0;
        end
        else if (!res.caps && res.ch >= UPPER_A && res.ch <= UPPER_Z)
        begin
            char_fold = res.ch + CASE_OFS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg    <= res.hit;
        char_reg   <= char_fold;
        status_reg <= res.status;
    end

    assign busy     = ctrl_busy;
    assign done     = done_reg;
    assign hit      = hit_reg;
    assign char_out = char_reg;
    assign status   = status_reg;

endmodule

`default_nettype wire

FILE: design/sclt_checker.sv
// Port-level checks for the sorted code lookup table, bound to the top level.
// Uses only the top level's ports.
`default_nettype none

module sclt_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic       hit,
    input wire logic [7:0] char_out,
    input wire logic       status
);

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |=> done)
        else $error("No result strobe after a transaction completed.");

    a_hit_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> !status)
        else $error("Lookup hit reported with a nonzero status.");

    a_miss_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (char_out == 8'h00))
        else $error("Result without a hit carries a character.");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("Busy rose without a command transaction.");

endmodule

bind sorted_code_lookup_table sclt_checker u_sclt_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .hit     (hit),
    .char_out(char_out),
    .status  (status)
);

`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for sorted_code_lookup_table: directed rows, then random traffic.
// It keeps its own sorted table, mirrors inserts and binary-search lookups, and checks each reply.
// Depends on sclt_pkg and the sorted_code_lookup_table RTL.
`timescale 1ns / 1ps

module tb;
    import sclt_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int ITEM_COUNT = 1750;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [CHAR_W-1:0] UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_GAP = 8'h20;

    typedef struct packed {
        logic              hit;
        logic [CHAR_W-1:0] char_out;
        logic              status;
    } reply_t;

    typedef struct packed {
        logic              cmd;
        logic [CODE_W-1:0] key_code;
        logic [CHAR_W-1:0] char_in;
        logic              caps;
        logic              typed;
        reply_t            reply;
    } stim_row_t;

    localparam reply_t EMPTY_REPLY = '{1'b0, 8'h00, STATUS_OK};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              cmd = CMD_INSERT;
    logic [CODE_W-1:0] key_code = '0;
    logic [CHAR_W-1:0] char_in = '0;
    logic              caps = 1'b0;
    logic              busy;
    logic              done;
    logic              hit;
    logic [CHAR_W-1:0] char_out;
    logic              status;

    logic [CODE_W-1:0] tbl_code [DEPTH];
    logic [CHAR_W-1:0] tbl_char [DEPTH];
    int                tbl_used = 0;
    reply_t            table_reply_q [$];
    int                mismatch_count = 0;
    int                idle_cycles = 0;
    int                calm_left = 0;

    stim_row_t directed_rows [0:24] = '{
        '{CMD_LOOKUP, 16'h0000, 8'h00, 1'b1, 1'b1, EMPTY_REPLY},
        '{CMD_LOOKUP, 16'hFFFF, 8'hFF, 1'b0, 1'b1, EMPTY_REPLY},
        '{CMD_INSERT, 16'h0000, 8'h41, 1'b0, 1'b1, EMPTY_REPLY},
        '{CMD_INSERT, 16'hFFFF, 8'hFF, 1'b1, 1'b1, EMPTY_REPLY},
        '{CMD_INSERT, 16'h8000, 8'h5A, 1'b0, 1'b1, EMPTY_REPLY},
        '{CMD_INSERT, 16'h8000, 8'h6D, 1'b1, 1'b1, EMPTY_REPLY},
        '{CMD_INSERT, 16'h8000, 8'h4D, 1'b0, 1'b1, EMPTY_REPLY},
        '{CMD_INSERT, 16'h1234, 8'h40, 1'b0, 1'b1, EMPTY_REPLY},
        '{CMD_INSERT, 16'h4321, 8'h5B, 1'b0, 1'b1, EMPTY_REPLY},
        '{CMD_INSERT, 16'h7FFF, 8'h00, 1'b0, 1'b1, EMPTY_REPLY},
        '{CMD_LOOKUP, 16'h0000, 8'h00, 1'b1, 1'b1, '{1'b1, 8'h41, STATUS_OK}},
        '{CMD_LOOKUP, 16'h0000, 8'hFF, 1'b0, 1'b1, '{1'b1, 8'h61, STATUS_OK}},
        '{CMD_LOOKUP, 16'hFFFF, 8'h00, 1'b0, 1'b1, '{1'b1, 8'hFF, STATUS_OK}},
        '{CMD_LOOKUP, 16'h1234, 8'h00, 1'b0, 1'b1, '{1'b1, 8'h40, STATUS_OK}},
        '{CMD_LOOKUP, 16'h4321, 8'h00, 1'b0, 1'b1, '{1'b1, 8'h5B, STATUS_OK}},
        '{CMD_LOOKUP, 16'h7FFF, 8'h00, 1'b1, 1'b1, '{1'b1, 8'h00, STATUS_OK}},
        '{CMD_LOOKUP, 16'h8000, 8'h00, 1'b1, 1'b0, EMPTY_REPLY},
        '{CMD_LOOKUP, 16'h8000, 8'h00, 1'b0, 1'b0, EMPTY_REPLY},
        '{CMD_LOOKUP, 16'h0001, 8'h00, 1'b1, 1'b1, EMPTY_REPLY},
        '{CMD_LOOKUP, 16'hFFFE, 8'h00, 1'b0, 1'b1, EMPTY_REPLY},
        '{CMD_INSERT, 16'h0000, 8'h7A, 1'b1, 1'b0, EMPTY_REPLY},
        '{CMD_LOOKUP, 16'h0000, 8'h00, 1'b0, 1'b0, EMPTY_REPLY},
        '{CMD_LOOKUP, 16'h5555, 8'h00, 1'b1, 1'b1, EMPTY_REPLY},
        '{CMD_INSERT, 16'hAAAA, 8'h5A, 1'b0, 1'b0, EMPTY_REPLY},
        '{CMD_LOOKUP, 16'hAAAA, 8'h00, 1'b0, 1'b0, EMPTY_REPLY}
    };

    sorted_code_lookup_table #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .key_code(key_code),
        .char_in (char_in),
        .caps    (caps),
        .done    (done),
        .hit     (hit),
        .char_out(char_out),
        .status  (status)
    );

    always #1 clk = ~clk;

    function automatic reply_t apply_table_op(input logic op, input logic [CODE_W-1:0] code,
                                              input logic [CHAR_W-1:0] ch, input logic as_stored);
        reply_t r;
        int     pos;
        int     lo;
        int     hi;
        int     mid;
        r = EMPTY_REPLY;
        if (op == CMD_INSERT)
        begin
            if (tbl_used >= DEPTH)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                pos = tbl_used;
                while (pos > 0 && tbl_code[pos-1] > code)
                begin
                    tbl_code[pos] = tbl_code[pos-1];
                    tbl_char[pos] = tbl_char[pos-1];
                    pos--;
                end
                tbl_code[pos] = code;
                tbl_char[pos] = ch;
                tbl_used++;
            end
        end
        else
        begin
            lo = 0;
            hi = tbl_used - 1;
            while (lo <= hi && !r.hit)
            begin
                mid = (lo + hi) / 2;
                if (tbl_code[mid] == code)
                begin
                    r.hit = 1'b1;
                    r.char_out = tbl_char[mid];
                    if (!as_stored && r.char_out >= UPPER_A && r.char_out <= UPPER_Z)
                        r.char_out = r.char_out + CASE_GAP;
                end
                else if (tbl_code[mid] < code)
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end
        end
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] draw_code(input logic op);
        int                pick;
        logic [CODE_W-1:0] c;
        pick = $urandom_range(0, 15);
        case (pick)
            0: c = '0;
            1: c = '1;
            2, 3, 4, 5, 6: c = CODE_W'($urandom_range(0, 63));
            default: c = CODE_W'($urandom);
        endcase
        if (op == CMD_LOOKUP && tbl_used > 0 && $urandom_range(0, 9) < 6)
        begin
            c = tbl_code[$urandom_range(0, tbl_used - 1)];
            if (pick == 0)
                c = c + 1'b1;
            else if (pick == 1)
                c = c - 1'b1;
        end
        return c;
    endfunction

    task automatic send_item(input logic op, input logic [CODE_W-1:0] code,
                             input logic [CHAR_W-1:0] ch, input logic cp,
                             input logic typed, input reply_t typed_reply);
        int     gap;
        reply_t r;
        if (calm_left > 0)
        begin
            calm_left--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 3);
            if ($urandom_range(0, 19) == 0)
                calm_left = $urandom_range(5, 30);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= op;
        key_code <= code;
        char_in <= ch;
        caps <= cp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = apply_table_op(op, code, ch, cp);
        table_reply_q.push_back(typed ? typed_reply : r);
    endtask

    always @(posedge clk)
    begin : reply_check
        reply_t want;
        if (rst_n && done)
        begin
            if (table_reply_q.size() == 0)
            begin
                $error("unexpected transaction: hit %0d, char_out %0h, status %0d",
                       hit, char_out, status);
                mismatch_count++;
            end
            else
            begin
                want = table_reply_q.pop_front();
                if (hit !== want.hit)
                begin
                    $error("hit: expected %0d, actual %0d", want.hit, hit);
                    mismatch_count++;
                end
                if (char_out !== want.char_out)
                begin
                    $error("char_out: expected %0h, actual %0h", want.char_out, char_out);
                    mismatch_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        stim_row_t         row;
        int                n;
        logic              op;
        logic [CODE_W-1:0] code;
        logic [CHAR_W-1:0] ch;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_item(row.cmd, row.key_code, row.char_in, row.caps, row.typed, row.reply);
        end
        for (n = $size(directed_rows); n < ITEM_COUNT; n++)
        begin
            if (tbl_used < DEPTH)
                op = ($urandom_range(0, 99) < 45) ? CMD_INSERT : CMD_LOOKUP;
            else
                op = ($urandom_range(0, 99) < 15) ? CMD_INSERT : CMD_LOOKUP;
            code = draw_code(op);
            if ($urandom_range(0, 1) == 1)
                ch = CHAR_W'($urandom_range(UPPER_A, UPPER_Z));
            else
                ch = CHAR_W'($urandom);
            send_item(op, code, ch, 1'($urandom), 1'b0, EMPTY_REPLY);
        end
        start <= 1'b0;
        while (table_reply_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
design/sclt_pkg.sv
design/sclt_mem.sv
design/sclt_ctrl.sv
design/sorted_code_lookup_table.sv
design/sclt_checker.sv
bench/tb.sv
